// ===== sv/crp_pkg.sv =====
// ----------------------------------------------------------------------------
// crp_pkg: shared types, constants and helpers of the Catmull-Rom tessellator
// Widths of the curve arithmetic follow from the segment sample count.
// ----------------------------------------------------------------------------
`default_nettype none

package crp_pkg;

  // Field widths
  localparam int POS_W   = 12;
  localparam int CURVE_W = 16;
  localparam int IDX_W   = 6;
  localparam int STEP_W  = 24;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(25);

  // Point history
  localparam int HIST_DEPTH = 4;
  localparam int KC_W       = $clog2(HIST_DEPTH + 1);

  // Segment queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QAW         = $clog2(QUEUE_DEPTH);

  // Samples per segment and derived arithmetic widths
  localparam int    SAMPLES_PER_SEGMENT = 10;
  localparam int    JW  = (SAMPLES_PER_SEGMENT > 1) ? $clog2(SAMPLES_PER_SEGMENT) : 1;
  localparam longint N3  = longint'(SAMPLES_PER_SEGMENT) * SAMPLES_PER_SEGMENT *
                           SAMPLES_PER_SEGMENT;
  localparam longint DEN = 2 * N3;
  localparam longint LIM = 65536 * DEN;
  localparam longint OFS = N3 + 32768 * DEN;
  localparam int    TW  = $clog2(N3 + 1);
  localparam int    PW  = TW + 17;
  localparam int    VW  = TW + 20;
  localparam int    DW  = $clog2(DEN + 1);
  localparam int    WW  = VW + DW + 6;
  localparam int    RW  = DW + CURVE_W;
  localparam int    DIV_STAGES = 2;

  // Reciprocal of the denominator: floor(r * RECIP_M / 2^RECIP_K) equals
  // floor(r / DEN) for every r below 2^RW
  localparam int     RECIP_K   = RW + DW;
  localparam int     MW        = RW + 2;
  localparam int     PRW       = RECIP_K + CURVE_W;
  localparam longint RECIP_M_L = ((longint'(1) << RECIP_K) + DEN - 1) / DEN;
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP_M_L);

  localparam logic signed [VW-1:0] DEN_V = VW'(DEN);
  localparam logic signed [WW-1:0] OFS_W = WW'(OFS);
  localparam logic signed [WW-1:0] LIM_W = WW'(LIM);
  localparam logic [RW-1:0]        REM_MAX = RW'(LIM - 1);

  // Basis tables over the sample index
  localparam int TAB_JN2 = 0;
  localparam int TAB_J2N = 1;
  localparam int TAB_J3  = 2;

  typedef logic [TW-1:0] tab_t [SAMPLES_PER_SEGMENT];

  function automatic tab_t make_tab(int kind);
    tab_t   t;
    longint jj;
    for (int i = 0; i < SAMPLES_PER_SEGMENT; i++) begin
      jj = longint'(i);
      case (kind)
        TAB_JN2: t[i] = TW'(jj * SAMPLES_PER_SEGMENT * SAMPLES_PER_SEGMENT);
        TAB_J2N: t[i] = TW'(jj * jj * SAMPLES_PER_SEGMENT);
        default: t[i] = TW'(jj * jj * jj);
      endcase
    end
    return t;
  endfunction

  localparam tab_t JN2_TAB = make_tab(TAB_JN2);
  localparam tab_t J2N_TAB = make_tab(TAB_J2N);
  localparam tab_t J3_TAB  = make_tab(TAB_J3);

  // Four kept points, entry 0 newest
  typedef struct packed {
    logic [HIST_DEPTH-1:0][POS_W-1:0] px;
    logic [HIST_DEPTH-1:0][POS_W-1:0] py;
  } seg_t;

  // Per-axis polynomial coefficients
  typedef struct packed {
    logic signed [POS_W-1:0] p1;
    logic signed [POS_W:0]   a;
    logic signed [15:0]      b;
    logic signed [15:0]      c;
  } coef_t;

  // Per-axis products for one sample
  typedef struct packed {
    logic signed [POS_W-1:0] p1;
    logic signed [PW-1:0]    ta;
    logic signed [PW-1:0]    tb;
    logic signed [PW-1:0]    tc;
  } prod_t;

  function automatic coef_t axis_coef(logic [HIST_DEPTH-1:0][POS_W-1:0] p);
    coef_t             r;
    logic signed [15:0] s0, s1, s2, s3, d;
    s0 = 16'($signed(p[0]));
    s1 = 16'($signed(p[1]));
    s2 = 16'($signed(p[2]));
    s3 = 16'($signed(p[3]));
    d    = s2 - s0;
    r.p1 = $signed(p[1]);
    r.a  = d[POS_W:0];
    r.b  = (s0 <<< 1) - (s1 <<< 2) - s1 + (s2 <<< 2) - s3;
    r.c  = s1 + (s1 <<< 1) - s0 - (s2 <<< 1) - s2 + s3;
    return r;
  endfunction

  function automatic prod_t mul_terms(coef_t c, logic [JW-1:0] j);
    prod_t r;
    r.p1 = c.p1;
    r.ta = PW'(c.a) * PW'($signed({1'b0, JN2_TAB[j]}));
    r.tb = PW'(c.b) * PW'($signed({1'b0, J2N_TAB[j]}));
    r.tc = PW'(c.c) * PW'($signed({1'b0, J3_TAB[j]}));
    return r;
  endfunction

  function automatic logic signed [VW-1:0] sum_terms(prod_t p);
    return VW'(p.p1) * DEN_V + VW'(p.ta) + VW'(p.tb) + VW'(p.tc);
  endfunction

  // Scale to Q12.4 with rounding offset, bias into unsigned range, clamp
  function automatic logic [RW-1:0] make_rem(logic signed [VW-1:0] v);
    logic signed [WW-1:0] w;
    logic [RW-1:0]        r;
    w = (WW'(v) <<< 4) + OFS_W;
    if (w[WW-1]) begin
      r = '0;
    end else if (w >= LIM_W) begin
      r = REM_MAX;
    end else begin
      r = w[RW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/crp_sample_if.sv =====
// ----------------------------------------------------------------------------
// crp_sample_if: position sample channel
// Valid/ready channel carrying one integer position sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface crp_sample_if;
  logic                               valid;
  logic                               ready;
  logic signed [crp_pkg::POS_W-1:0]   pos_x;
  logic signed [crp_pkg::POS_W-1:0]   pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

// ===== sv/crp_curve_if.sv =====
// ----------------------------------------------------------------------------
// crp_curve_if: curve sample channel
// Valid/ready channel carrying one tessellated curve sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface crp_curve_if;
  logic                               valid;
  logic                               ready;
  logic signed [crp_pkg::CURVE_W-1:0] curve_x;
  logic signed [crp_pkg::CURVE_W-1:0] curve_y;
  logic [crp_pkg::IDX_W-1:0]          sample_index;
  logic                               last_sample;

  modport source (output valid, output curve_x, output curve_y, output sample_index,
                  output last_sample, input ready);
  modport sink   (input valid, input curve_x, input curve_y, input sample_index,
                  input last_sample, output ready);
endinterface

`default_nettype wire

// ===== sv/crp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// crp_cfg_if: configuration write channel
// Valid/ready channel carrying the minimum step threshold.
// ----------------------------------------------------------------------------
`default_nettype none

interface crp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [crp_pkg::STEP_W-1:0]       min_step_sq;

  modport source (output valid, output min_step_sq, input ready);
  modport sink   (input valid, input min_step_sq, output ready);
endinterface

`default_nettype wire

// ===== sv/crp_front.sv =====
// ----------------------------------------------------------------------------
// crp_front: sample filter and point history
// Accepts samples, drops those too close to the newest point, keeps four
// points and hands each newly formed segment to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_front (
  input  wire logic        clk,
  input  wire logic        rst,
  crp_sample_if.sink       sample,
  crp_cfg_if.sink          cfg,
  output logic             push_valid,
  input  wire logic        push_ready,
  output crp_pkg::seg_t    push_seg
);
  import crp_pkg::*;

  localparam int D2W = 2 * POS_W + 3;

  logic [STEP_W-1:0]                min_step_sq;
  logic [HIST_DEPTH-1:0][POS_W-1:0] hist_x, hist_y;
  logic [HIST_DEPTH-1:0][POS_W-1:0] hist_x_next, hist_y_next;
  logic [KC_W-1:0]                  kept_count;

  logic signed [POS_W:0]  dx, dy;
  logic signed [D2W-1:0]  sqx, sqy;
  logic [D2W-1:0]         d2;
  logic                   accept, keep;

  assign cfg.ready    = 1'b1;
  assign sample.ready = push_ready;
  assign accept       = sample.valid && sample.ready;

  assign dx  = (POS_W+1)'(sample.pos_x) - (POS_W+1)'($signed(hist_x[0]));
  assign dy  = (POS_W+1)'(sample.pos_y) - (POS_W+1)'($signed(hist_y[0]));
  assign sqx = D2W'(dx) * D2W'(dx);
  assign sqy = D2W'(dy) * D2W'(dy);
  assign d2  = sqx + sqy;

  // first point always kept; equal distance is dropped
  assign keep = (kept_count == '0) || (d2 > D2W'(min_step_sq));

  assign hist_x_next = {hist_x[HIST_DEPTH-2:0], sample.pos_x};
  assign hist_y_next = {hist_y[HIST_DEPTH-2:0], sample.pos_y};

  assign push_valid  = accept && keep && (kept_count >= KC_W'(HIST_DEPTH - 1));
  assign push_seg.px = hist_x_next;
  assign push_seg.py = hist_y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_step_sq <= STEP_RESET;
    end else if (cfg.valid) begin
      min_step_sq <= cfg.min_step_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_x     <= '0;
      hist_y     <= '0;
      kept_count <= '0;
    end else if (accept && keep) begin
      hist_x <= hist_x_next;
      hist_y <= hist_y_next;
      if (kept_count < KC_W'(HIST_DEPTH)) begin
        kept_count <= kept_count + KC_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/crp_fifo.sv =====
// ----------------------------------------------------------------------------
// crp_fifo: segment queue
// Short first-in first-out queue of four-point segments.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire crp_pkg::seg_t  push_seg,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output crp_pkg::seg_t       pop_seg
);
  import crp_pkg::*;

  seg_t           mem [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic           do_push, do_pop;

  assign push_ready = (count != (QAW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_seg    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/crp_div.sv =====
// ----------------------------------------------------------------------------
// crp_div: pipelined constant divider
// Divides by the fixed curve denominator through a reciprocal multiply,
// two stages advancing under a shared enable.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [crp_pkg::RW-1:0]        rem_in,
  output logic [crp_pkg::CURVE_W-1:0]        quot
);
  import crp_pkg::*;

  logic [PRW-1:0] prod;

  // multiply by the reciprocal, then keep the integer part
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PRW'(rem_in) * PRW'(RECIP_M);
      quot <= prod[PRW-1:RECIP_K];
    end
  end

endmodule

`default_nettype wire

// ===== sv/crp_back.sv =====
// ----------------------------------------------------------------------------
// crp_back: segment evaluator
// Walks the sample index over each queued segment and evaluates both axes
// through a stalling pipeline ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire crp_pkg::seg_t  pop_seg,
  crp_curve_if.source         curve
);
  import crp_pkg::*;

  logic adv;

  // sequencer
  logic          seg_active;
  coef_t         cx, cy;
  logic [JW-1:0] j;
  logic          last_j;

  // stage 1: products
  logic          s1_valid, s1_last;
  logic [JW-1:0] s1_j;
  prod_t         s1_px, s1_py;

  // stage 2: polynomial value
  logic                 s2_valid, s2_last;
  logic [JW-1:0]        s2_j;
  logic signed [VW-1:0] s2_vx, s2_vy;

  // stage 3: scaled, biased and clamped dividend
  logic          s3_valid, s3_last;
  logic [JW-1:0] s3_j;
  logic [RW-1:0] s3_rx, s3_ry;

  // divider sideband
  logic          dv [DIV_STAGES];
  logic          dl [DIV_STAGES];
  logic [JW-1:0] dj [DIV_STAGES];
  logic [CURVE_W-1:0] qx, qy;

  assign adv       = !curve.valid || curve.ready;
  assign last_j    = (j == JW'(SAMPLES_PER_SEGMENT - 1));
  assign pop_ready = !seg_active || (adv && last_j);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_active <= 1'b0;
    end else if (pop_valid && pop_ready) begin
      seg_active <= 1'b1;
    end else if (adv && seg_active && last_j) begin
      seg_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cx <= axis_coef(pop_seg.px);
      cy <= axis_coef(pop_seg.py);
      j  <= '0;
    end else if (adv && seg_active) begin
      j <= j + JW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= seg_active;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_j  <= j;
      s1_last <= last_j;
      s1_px <= mul_terms(cx, j);
      s1_py <= mul_terms(cy, j);
      s2_j  <= s1_j;
      s2_last <= s1_last;
      s2_vx <= sum_terms(s1_px);
      s2_vy <= sum_terms(s1_py);
      s3_j  <= s2_j;
      s3_last <= s2_last;
      s3_rx <= make_rem(s2_vx);
      s3_ry <= make_rem(s2_vy);
    end
  end

  crp_div u_div_x (.clk(clk), .en(adv), .rem_in(s3_rx), .quot(qx));
  crp_div u_div_y (.clk(clk), .en(adv), .rem_in(s3_ry), .quot(qy));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv[s] <= 1'b0;
      end
    end else if (adv) begin
      dv[0] <= s3_valid;
      for (int s = 1; s < DIV_STAGES; s++) begin
        dv[s] <= dv[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dj[0] <= s3_j;
      dl[0] <= s3_last;
      for (int s = 1; s < DIV_STAGES; s++) begin
        dj[s] <= dj[s-1];
        dl[s] <= dl[s-1];
      end
    end
  end

  // output register; unbias the quotient by flipping its top bit
  always_ff @(posedge clk) begin
    if (rst) begin
      curve.valid <= 1'b0;
    end else if (adv) begin
      curve.valid <= dv[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      curve.curve_x      <= $signed({~qx[CURVE_W-1], qx[CURVE_W-2:0]});
      curve.curve_y      <= $signed({~qy[CURVE_W-1], qy[CURVE_W-2:0]});
      curve.sample_index <= IDX_W'(dj[DIV_STAGES-1]);
      curve.last_sample  <= dl[DIV_STAGES-1];
    end
  end

endmodule

`default_nettype wire

// ===== sv/catmull_rom_path_tessellator_core.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_path_tessellator_core: Catmull-Rom path tessellator
// Filters position samples into a four-point history and emits the samples
// of each new uniform Catmull-Rom segment in Q12.4.
// ----------------------------------------------------------------------------
// Each sample on the sample channel is one transaction. The first sample after
// reset is always kept; a later one is kept only when its squared distance from
// the newest kept point is strictly greater than min_step_sq (reset value 25).
// From the fourth kept point on, every kept sample produces SAMPLES_PER_SEGMENT
// (10) curve transactions, sample_index 0..9, last_sample set on the final one.
// The control points are newest, second, third newest and oldest kept point.
// The sample channel takes one transaction per cycle while the two-entry
// segment queue has room; a dropped sample or one that only fills the history
// also waits for that room. The evaluator issues one curve sample per cycle
// while the curve channel is not stalled, so a segment occupies it for 10
// samples, and it takes the next queued segment as its last index advances.
// A sample index passes through the product, sum and clamp registers, the
// prod and quot registers of the reciprocal multiply for the division by the
// fixed denominator, and the output register.
// Curve stalls hold the whole evaluator; the queue lets the sample side keep
// taking transactions meanwhile. Write min_step_sq only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module catmull_rom_path_tessellator_core (
  input  wire logic    clk,
  input  wire logic    rst,
  crp_sample_if.sink   sample,
  crp_curve_if.source  curve,
  crp_cfg_if.sink      cfg
);
  import crp_pkg::*;

  // front to queue
  logic push_valid, push_ready;
  seg_t push_seg;

  // queue to evaluator
  logic pop_valid, pop_ready;
  seg_t pop_seg;

  // filter samples, advance the history, push complete segments
  crp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_seg   (push_seg)
  );

  // hold segments while the evaluator is busy or stalled
  crp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_seg   (push_seg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_seg    (pop_seg)
  );

  // evaluate each segment at every sample index
  crp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_seg    (pop_seg),
    .curve      (curve)
  );

endmodule

`default_nettype wire
